// File: src/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/phx_pkg.sv
package phx_pkg;

    localparam int unsigned ROUNDS = 10;
    localparam int unsigned LANES  = 4;
    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] MUL_A  = 32'hD2511F53;
    localparam logic [WORD_W-1:0] MUL_B  = 32'hCD9E8D57;
    localparam logic [WORD_W-1:0] WEYL_A = 32'h9E3779B9;
    localparam logic [WORD_W-1:0] WEYL_B = 32'hBB67AE85;

    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_KEY_LOW    = 3'd0;
    localparam logic [2:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [2:0] REG_CTR_OFFSET = 3'd2;
    localparam logic [2:0] REG_ELEM_TOTAL = 3'd3;
    localparam logic [2:0] REG_RANGE_LOW  = 3'd4;
    localparam logic [2:0] REG_RANGE_HIGH = 3'd5;

    localparam logic [WORD_W-1:0] RANGE_HIGH_RESET = 32'h0001_0000;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [LANES-1:0]             mask;
        logic [LANES-1:0][WORD_W-1:0] w;
    } phx_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k0;
    } phx_key_t;

    typedef struct packed {
        logic [LANES-1:0]             mask;
        logic [LANES-1:0][WORD_W-1:0] w;
        logic [LANES-1:0][WORD_W-1:0] q;
    } phx_map_t;

    // Key offset after r bumps by a Weyl constant, modulo 2^32.
    function automatic word_t weyl_offset(input word_t c, input int unsigned r);
        logic [2*WORD_W-1:0] p;
        p = (2*WORD_W)'(c) * (2*WORD_W)'(r);
        return p[WORD_W-1:0];
    endfunction

endpackage

// File: src/phx_round.sv
module phx_round import phx_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  phx_item_t in_item,
    input  phx_key_t  key,
    output logic      out_valid,
    output phx_item_t out_item
);

    logic [2*WORD_W-1:0] prod_a;
    logic [2*WORD_W-1:0] prod_b;
    phx_item_t           item_next;
    phx_item_t           item_reg;
    logic                valid_reg;

    always_comb
    begin
        prod_a = (2*WORD_W)'(MUL_A) * (2*WORD_W)'(in_item.w[0]);
        prod_b = (2*WORD_W)'(MUL_B) * (2*WORD_W)'(in_item.w[2]);
        item_next.mask = in_item.mask;
        item_next.w[0] = prod_b[2*WORD_W-1:WORD_W] ^ in_item.w[1] ^ key.k0;
        item_next.w[1] = prod_b[WORD_W-1:0];
        item_next.w[2] = prod_a[2*WORD_W-1:WORD_W] ^ in_item.w[3] ^ key.k1;
        item_next.w[3] = prod_a[WORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// File: src/phx_map.sv
module phx_map import phx_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  phx_item_t          in_item,
    input  logic signed [WORD_W:0] range_diff,
    output logic               out_valid,
    output phx_map_t           out_map
);

    logic signed [2*WORD_W+1:0] prod [LANES];
    phx_map_t                   map_next;
    phx_map_t                   map_reg;
    logic                       valid_reg;

    // An arithmetic product keeps the floor correct for a reversed range.
    always_comb
    begin
        map_next.mask = in_item.mask;
        map_next.w    = in_item.w;
        for (int i = 0; i < LANES; i++)
        begin
            prod[i] = $signed({1'b0, in_item.w[i]}) * range_diff;
            map_next.q[i] = prod[i][2*WORD_W-1:WORD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            map_reg <= map_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_map   = map_reg;

endmodule

// File: src/philox_uniform_generator_top.sv
// Channel   | Direction | Request contents
// ----------+-----------+-----------------------------------------------------
// s_*       | in        | tdata: thread_index
// m_*       | out       | tdata: raw_word0..3, value0..3; tuser: lane_valid
// APB p*    | in/out    | key_low, key_high, ctr_offset, elem_total,
//           |           | range_low, range_high at byte addresses 0 to 20
//
// One request is taken every cycle unless m_* stalls; its result reaches m_*
// through ROUNDS + 3 register stages.
// Those stages are the counter stage, one stage per Philox round, the range
// multiply stage and the output register.
// All stages advance together whenever the output register is empty or taken.
// Reset clears every valid bit and loads the register reset values.
module philox_uniform_generator_top import phx_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [WORD_W-1:0]       s_tdata,   // [31:0] thread_index
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [8*WORD_W-1:0]     m_tdata,   // raw_word0..3, then value0..3
    output logic [LANES-1:0]        m_tuser,   // [3:0] lane_valid
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [WORD_W-1:0]       pwdata,
    output logic [WORD_W-1:0]       prdata,
    output logic                    pready
);

    word_t key_low_reg;
    word_t key_high_reg;
    word_t ctr_offset_reg;
    word_t elem_total_reg;
    word_t range_low_reg;
    word_t range_high_reg;
    logic signed [WORD_W:0] range_diff_reg;

    logic      cfg_write;
    logic [2:0] cfg_sel;
    logic      en;

    phx_item_t s0_item_next;
    phx_item_t s0_item_reg;
    logic      s0_valid_reg;

    logic      valid_chain [ROUNDS+1];
    phx_item_t item_chain  [ROUNDS+1];
    phx_key_t  round_key   [ROUNDS];

    logic      map_valid;
    phx_map_t  map_out;

    logic                     out_valid_reg;
    logic [8*WORD_W-1:0]      out_data_next;
    logic [8*WORD_W-1:0]      out_data_reg;
    logic [LANES-1:0]         out_user_reg;

    assign pready    = 1'b1;
    assign cfg_sel   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            ctr_offset_reg <= '0;
            elem_total_reg <= '0;
            range_low_reg  <= '0;
            range_high_reg <= RANGE_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_KEY_LOW:    key_low_reg    <= pwdata;
                REG_KEY_HIGH:   key_high_reg   <= pwdata;
                REG_CTR_OFFSET: ctr_offset_reg <= pwdata;
                REG_ELEM_TOTAL: elem_total_reg <= pwdata;
                REG_RANGE_LOW:  range_low_reg  <= pwdata;
                REG_RANGE_HIGH: range_high_reg <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_KEY_LOW:    prdata = key_low_reg;
            REG_KEY_HIGH:   prdata = key_high_reg;
            REG_CTR_OFFSET: prdata = ctr_offset_reg;
            REG_ELEM_TOTAL: prdata = elem_total_reg;
            REG_RANGE_LOW:  prdata = range_low_reg;
            REG_RANGE_HIGH: prdata = range_high_reg;
            default:        prdata = '0;
        endcase
    end

    // The range width is registered and follows the registers in the next cycle,
    // long before a new request can reach the multiply stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_diff_reg <= (WORD_W+1)'(RANGE_HIGH_RESET);
        end
        else
        begin
            range_diff_reg <= $signed({range_high_reg[WORD_W-1], range_high_reg})
                            - $signed({range_low_reg[WORD_W-1], range_low_reg});
        end
    end

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_comb
    begin
        s0_item_next.w[0] = ctr_offset_reg + s_tdata;
        for (int i = 1; i < LANES; i++)
        begin
            s0_item_next.w[i] = '0;
        end
        for (int i = 0; i < LANES; i++)
        begin
            s0_item_next.mask[i] = {s_tdata, 2'(i)} < {2'b00, elem_total_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_item_reg <= s0_item_next;
        end
    end

    assign valid_chain[0] = s0_valid_reg;
    assign item_chain[0]  = s0_item_reg;

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        assign round_key[r].k0 = key_low_reg  + weyl_offset(WEYL_A, r);
        assign round_key[r].k1 = key_high_reg + weyl_offset(WEYL_B, r);

        phx_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (valid_chain[r]),
            .in_item   (item_chain[r]),
            .key       (round_key[r]),
            .out_valid (valid_chain[r+1]),
            .out_item  (item_chain[r+1])
        );
    end

    phx_map u_map (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (valid_chain[ROUNDS]),
        .in_item    (item_chain[ROUNDS]),
        .range_diff (range_diff_reg),
        .out_valid  (map_valid),
        .out_map    (map_out)
    );

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            out_data_next[i*WORD_W +: WORD_W]         = map_out.w[i];
            out_data_next[(LANES+i)*WORD_W +: WORD_W] = map_out.q[i] + range_low_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= map_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= map_out.mask;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: src/phx_checker.sv
`include "assert_macros.svh"

module phx_checker import phx_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [WORD_W-1:0]   s_tdata,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [8*WORD_W-1:0] m_tdata,
    input logic [LANES-1:0]    m_tuser,
    input logic                psel,
    input logic                penable,
    input logic                pwrite,
    input logic [ADDR_W-1:0]   paddr,
    input logic [WORD_W-1:0]   pwdata,
    input logic [WORD_W-1:0]   prdata,
    input logic                pready
);

    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `ASSERT_CLK(a_ready_follows, m_tready |-> s_tready, "input stalled while output drains")
    `ASSERT_CLK(a_ready_empty, !m_tvalid |-> s_tready, "input stalled with empty output")
    `ASSERT_CLK(a_lane_prefix, m_tvalid |-> (m_tuser == 4'h0 || m_tuser == 4'h1 || m_tuser == 4'h3 || m_tuser == 4'h7 || m_tuser == 4'hF), "lane mask not a prefix")
    `ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind philox_uniform_generator_top phx_checker u_phx_checker (.*);
